### design/tszc_pkg.sv
// package for the three-sum zero counter
// shared constants, controller command and status structs, state enum
package tszc_pkg;

  localparam int MaxElements = 64;
  localparam int ValueBits   = 16;
  localparam int IdxBits     = $clog2(MaxElements);
  localparam int TotBits     = $clog2(MaxElements + 1);
  localparam int CntBits     = 12;
  localparam int MinSet      = 3;
  localparam int SumBits     = ValueBits + 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_SW_INIT,
    ST_SW_RDI,
    ST_SW_RD,
    ST_SW_CMP,
    ST_OUT_PRE,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // store an incoming element
    logic clear;       // start a new set
    logic pass_start;  // start a sort pass
    logic sort_rd;     // read pair k, k+1
    logic sort_cmp;    // compare pair, update k
    logic sort_wr;     // write swapped second word
    logic sw_init;     // i, counters and pass end = 0
    logic sw_rdi;      // read element i, set lo and hi
    logic sw_rd;       // read lo and hi
    logic sw_cmp;      // evaluate sum, move pointers
    logic next_i;      // i++
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic few;
    logic pass_done;    // k + 1 reached the pass end
    logic swap_now;     // current pair out of order
    logic sort_more;    // another pass needed
    logic lo_lt_hi;
    logic i_done;
  } sts_t;

endpackage

### design/three_sum_zero_counter_unit.sv
// Three-sum zero counter. Elements load one per cycle while ready is high;
// after the last element the block sorts the set with an early-exit bubble
// sort and then runs the two-pointer sweep, all through one two-read store
// port. One result follows each set; no element is taken until it is
// delivered.
// Top level: joins tszc_ctrl and tszc_datapath, depends on tszc_pkg.
module three_sum_zero_counter_unit import tszc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ValueBits-1:0] value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CntBits-1:0]   triple_count_o,
  output logic [CntBits-1:0]   step_count_o,
  output logic                 too_few_o,
  output logic                 overflowed_o
);

  cmd_t cmd;
  sts_t sts;

  tszc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_last_i(last_i), .in_ready_o,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  tszc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .value_i, .sts_o(sts),
    .triple_count_o, .step_count_o, .too_few_o, .overflowed_o
  );

endmodule

### design/tszc_datapath.sv
// datapath: element store, sort pass counters, sweep pointers and counters
// depends on tszc_pkg
module tszc_datapath import tszc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [ValueBits-1:0] value_i,
  output sts_t                 sts_o,
  output logic [CntBits-1:0]   triple_count_o,
  output logic [CntBits-1:0]   step_count_o,
  output logic                 too_few_o,
  output logic                 overflowed_o
);

  logic [ValueBits-1:0] mem_q [MaxElements];
  logic [ValueBits-1:0] rd_a_q, rd_b_q, val_i_q;
  logic [TotBits-1:0]   total_q;
  logic                 ovf_q;
  logic [IdxBits-1:0]   k_q, lo_q, hi_q, i_q;
  logic [TotBits-1:0]   pass_end_q;
  logic                 swapped_q;
  logic [CntBits-1:0]   trip_q, step_q;

  logic                 swap;
  logic signed [SumBits-1:0] sum;
  logic [IdxBits-1:0]   ra, rb, wa;
  logic [ValueBits-1:0] wd;
  logic                 we;

  assign swap = $signed(rd_a_q) > $signed(rd_b_q);
  assign sum  = SumBits'($signed(val_i_q)) + SumBits'($signed(rd_a_q))
              + SumBits'($signed(rd_b_q));

  // memory port addressing
  always_comb begin
    ra = k_q;
    rb = k_q + IdxBits'(1);
    // an ordered pair moves k on, so fetch the next pair right away
    if (cmd_i.sort_cmp && !swap) begin
      ra = k_q + IdxBits'(1);
      rb = k_q + IdxBits'(2);
    end
    if (cmd_i.sw_rdi) ra = i_q;
    if (cmd_i.sw_rd) begin
      ra = lo_q;
      rb = hi_q;
    end
    we = 1'b0;
    wa = total_q[IdxBits-1:0];
    wd = value_i;
    if (cmd_i.load && total_q < TotBits'(MaxElements)) we = 1'b1;
    if (cmd_i.sort_cmp && swap) begin
      we = 1'b1;
      wa = k_q;
      wd = rd_b_q;
    end
    if (cmd_i.sort_wr) begin
      we = 1'b1;
      wa = k_q + IdxBits'(1);
      wd = rd_a_q;
    end
  end

  // element store, registered reads
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
    if (cmd_i.sw_rdi) val_i_q <= mem_q[ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0; ovf_q <= 1'b0; k_q <= '0; lo_q <= '0; hi_q <= '0;
      i_q <= '0; pass_end_q <= '0; swapped_q <= 1'b0;
      trip_q <= '0; step_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        total_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.load) begin
        if (total_q < TotBits'(MaxElements)) total_q <= total_q + TotBits'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.pass_start) begin
        k_q <= '0;
        swapped_q <= 1'b0;
        if (pass_end_q == '0) pass_end_q <= total_q;
        else pass_end_q <= pass_end_q - TotBits'(1);
      end
      if (cmd_i.sort_cmp) begin
        if (swap) swapped_q <= 1'b1;
        else k_q <= k_q + IdxBits'(1);
      end
      // after the swap write, k moves to the next pair
      if (cmd_i.sort_wr) k_q <= k_q + IdxBits'(1);
      if (cmd_i.sw_init) begin
        i_q <= '0; trip_q <= '0; step_q <= '0; pass_end_q <= '0;
      end
      if (cmd_i.sw_rdi) begin
        lo_q <= i_q + IdxBits'(1);
        hi_q <= IdxBits'(total_q - TotBits'(1));
      end
      if (cmd_i.sw_cmp) begin
        if (step_q != '1) step_q <= step_q + CntBits'(1);
        if (sum == '0) begin
          if (trip_q != '1) trip_q <= trip_q + CntBits'(1);
          lo_q <= lo_q + IdxBits'(1);
          hi_q <= hi_q - IdxBits'(1);
        end else if (sum > 0) hi_q <= hi_q - IdxBits'(1);
        else lo_q <= lo_q + IdxBits'(1);
      end
      if (cmd_i.next_i) i_q <= i_q + IdxBits'(1);
    end
  end

  // status; pass end register holds n minus passes done
  // the last index has no pair to its right, so the sweep stops one short
  assign sts_o.few       = total_q < TotBits'(MinSet);
  assign sts_o.pass_done = (TotBits'(k_q) + TotBits'(1)) >= pass_end_q;
  assign sts_o.swap_now  = swap;
  assign sts_o.sort_more = swapped_q && pass_end_q > TotBits'(2);
  assign sts_o.lo_lt_hi  = lo_q < hi_q;
  assign sts_o.i_done    = (TotBits'(i_q) + TotBits'(2)) >= total_q;

  assign triple_count_o = sts_o.few ? '0 : trip_q;
  assign step_count_o   = sts_o.few ? '0 : step_q;
  assign too_few_o      = sts_o.few;
  assign overflowed_o   = ovf_q;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotBits'(MaxElements)) else $error("element total past capacity");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> total_q == TotBits'(MaxElements)) else $error("overflow while not full");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trip_q <= step_q) else $error("triples exceed steps");
`endif

endmodule

### design/tszc_ctrl.sv
// controller state machine for the three-sum zero counter
// depends on tszc_pkg
module tszc_ctrl import tszc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = ST_SW_INIT;
        end
      end
      ST_SW_INIT: begin
        // pass end is cleared here so the first pass starts at n
        cmd_o.sw_init = 1'b1;
        if (sts_i.few) state_d = ST_OUT;
        else state_d = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        cmd_o.pass_start = 1'b1;
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        cmd_o.sort_rd = 1'b1;
        state_d = ST_SORT_WR;
      end
      ST_SORT_WR: begin
        if (sts_i.pass_done) begin
          if (sts_i.sort_more) state_d = ST_SORT_RD;
          else state_d = ST_SW_RDI;
        end else begin
          cmd_o.sort_cmp = 1'b1;
          if (sts_i.swap_now) state_d = ST_SW_RD;
          else state_d = ST_SORT_WR;
        end
      end
      ST_SW_RD: begin
        // second half of a swap, reuse this state only inside the sort
        cmd_o.sort_wr = 1'b1;
        state_d = ST_SORT_CMP;
      end
      ST_SW_RDI: begin
        cmd_o.sw_rdi = 1'b1;
        state_d = ST_SW_CMP;
      end
      ST_SW_CMP: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.sw_rd = 1'b1;
          state_d = ST_OUT_PRE;
        end else if (sts_i.i_done) state_d = ST_OUT;
        else begin
          cmd_o.next_i = 1'b1;
          state_d = ST_SW_RDI;
        end
      end
      ST_OUT_PRE: begin
        cmd_o.sw_cmp = 1'b1;
        state_d = ST_SW_CMP;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("load and result at once");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> state_q == ST_LOAD) else $error("clear without return to load");
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sw_rd |=> cmd_o.sw_cmp) else $error("sweep read without compare");
`endif

endmodule
